@@ design/pbusn_pkg.sv @@
// shared constants, types and helpers for the point block normalizer
// no dependencies; imported by pbusn_ram users and the top level
`timescale 1ns / 1ps

package pbusn_pkg;

  localparam int MAX_POINTS  = 4096;
  localparam int COORD_WIDTH = 32;

  // port widths fixed by the interface
  localparam int IN_W  = 32;
  localparam int OUT_W = 16;

  // magnitudes are scaled down when coordinates exceed 32 bits
  localparam int SCALE_SHIFT = (COORD_WIDTH > 32) ? COORD_WIDTH - 32 : 0;
  // stored centered value, one extra bit for the subtraction
  localparam int CW_S   = COORD_WIDTH + 1;
  localparam int MAG_W  = COORD_WIDTH - SCALE_SHIFT;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int SUM_W  = COORD_WIDTH + CNT_W - 1;
  localparam int DSQ_W  = 2 * MAG_W;
  localparam int NORM_FRAC = 14;
  localparam int MEM_W  = 3 * CW_S;

  // shared divider sizes
  localparam int DIV_NW = (SUM_W > MAG_W + NORM_FRAC + 1) ? SUM_W : MAG_W + NORM_FRAC + 1;
  localparam int DIV_DW = (CNT_W > MAG_W) ? CNT_W : MAG_W;
  localparam int DIV_CW = $clog2(DIV_NW + 1);
  localparam int SQ_STEPS = DSQ_W / 2;
  localparam int SQ_CW  = $clog2(SQ_STEPS + 1);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam logic [DIV_NW-1:0] NORM_POS_MAX = DIV_NW'(32767);
  localparam logic [DIV_NW-1:0] NORM_NEG_MAX = DIV_NW'(32768);
  localparam logic [OUT_W-1:0]  NORM_POS_SAT = 16'h7fff;
  localparam logic [OUT_W-1:0]  NORM_NEG_SAT = 16'h8000;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_PASS,
    ST_SQRT,
    ST_READY,
    ST_FETCH_RD,
    ST_NORM_GO,
    ST_NORM_WAIT,
    ST_EMIT
  } state_t;

  typedef logic signed [CW_S-1:0] cval_t;

  // input coordinate taken as a COORD_WIDTH-bit two's complement value
  function automatic cval_t sext_coord(input logic [IN_W-1:0] v);
    logic [63:0] wide;
    logic signed [COORD_WIDTH-1:0] t;
    wide = {{32{v[IN_W-1]}}, v};
    t = wide[COORD_WIDTH-1:0];
    return CW_S'(t);
  endfunction

  // scaled magnitude of a centered value
  function automatic logic [MAG_W-1:0] mag_of(input cval_t c);
    logic [CW_S-1:0] a;
    a = c[CW_S-1] ? (~c + 1'b1) : c;
    return MAG_W'(a >> SCALE_SHIFT);
  endfunction

endpackage

@@ design/pbusn_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pbusn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/point_block_unit_sphere_normalize.sv @@
// point block unit-sphere normalizer top level
// depends on pbusn_pkg and pbusn_ram
`timescale 1ns / 1ps

// Usage
//   Command channel: a beat is taken when start is high and busy is low.
//   in_req_type 0 loads a point (in_coord_x/y/z, in_load_last), 1 fetches
//   the next normalized point. Loads give no result; each fetch gives one
//   result beat, a one-cycle strobe on out_valid with out_norm_x/y/z,
//   out_last and out_no_data. The receiver cannot stall.
//   Loads are taken one per cycle. A load with in_load_last starts the
//   block pass: three iterative centroid divides, a pipelined centering
//   and distance walk over the point memory, and a bit-serial square
//   root; busy stays high for the whole pass.
//   A fetch reads one memory word and runs three iterative divides on the
//   shared divider; busy stays high until the result strobe, so one
//   fetch is finished before the next is taken.
//   A fetch while loading answers the next cycle with out_no_data set.
//   Loads during readout are ignored. After the last point is read the
//   block is ready to load again.
//   Reset clears sums, counts, pointers and returns to loading; the point
//   memory is not cleared, every entry is written before it is read.

module point_block_unit_sphere_normalize (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_req_type,
  input  logic [pbusn_pkg::IN_W-1:0] in_coord_x,
  input  logic [pbusn_pkg::IN_W-1:0] in_coord_y,
  input  logic [pbusn_pkg::IN_W-1:0] in_coord_z,
  input  logic                      in_load_last,
  output logic                      out_valid,
  output logic [pbusn_pkg::OUT_W-1:0] out_norm_x,
  output logic [pbusn_pkg::OUT_W-1:0] out_norm_y,
  output logic [pbusn_pkg::OUT_W-1:0] out_norm_z,
  output logic                      out_last,
  output logic                      out_no_data
);

  import pbusn_pkg::*;

  state_t state_r, state_nxt;

  logic accept;
  logic signed [SUM_W-1:0] sum_r [3];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rptr_r;
  logic [1:0] axis_r;
  cval_t cent_r [3];

  // pass pipeline
  logic [CNT_W-1:0] pa_r;
  logic p1_vld_r, p2_vld_r, p3_vld_r;
  logic [ADDR_W-1:0] p1_addr_r;
  logic [MAG_W-1:0] m_r [3];
  logic [DSQ_W-1:0] sq_r [3];
  logic [DSQ_W-1:0] maxsq_r;
  logic issue;
  logic drained;
  logic [DSQ_W-1:0] dsq;
  cval_t cc [3];

  // divider
  logic [DIV_NW-1:0] dv_num_r;
  logic [DIV_DW-1:0] dv_rem_r;
  logic [DIV_DW-1:0] dv_den_r;
  logic [DIV_CW-1:0] dv_cnt_r;
  logic div_go;
  logic [DIV_NW-1:0] div_num_in;
  logic [DIV_DW-1:0] div_den_in;
  logic [DIV_DW:0] dv_sh;
  logic dv_q;

  // square root
  logic [DSQ_W-1:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [SQ_CW-1:0] sq_cnt_r;
  logic [DSQ_W-1:0] sq_t;
  logic [MAG_W-1:0] dist_val;

  // fetch
  cval_t fc_r [3];
  logic [OUT_W-1:0] nrm_r [3];
  logic fetch_end;

  // memory ports
  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;

  logic signed [SUM_W-1:0] abs_sum;
  logic [MAG_W-1:0] fmag;
  logic [DIV_NW-1:0] qsel;

  function automatic logic [OUT_W-1:0] sat_q(input logic [DIV_NW-1:0] q, input logic neg);
    logic [OUT_W-1:0] r;
    if (neg) begin
      r = (q > NORM_NEG_MAX) ? NORM_NEG_SAT : (~q[OUT_W-1:0] + 1'b1);
    end else begin
      r = (q > NORM_POS_MAX) ? NORM_POS_SAT : q[OUT_W-1:0];
    end
    return r;
  endfunction

  pbusn_ram #(.WIDTH(MEM_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept = start && !busy;

  // centering of the word returned by the memory
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cc[k] = cval_t'($signed(ram_rdata[k*CW_S +: CW_S]) - cent_r[k]);
    end
  end

  assign issue   = (state_r == ST_PASS) && (pa_r < count_r);
  assign drained = (pa_r >= count_r) && !p1_vld_r && !p2_vld_r && !p3_vld_r;
  assign dsq     = sq_r[0] + sq_r[1] + sq_r[2];
  assign dist_val = sq_res_r[MAG_W-1:0];
  assign fetch_end = (rptr_r + 1'b1) >= count_r;
  assign qsel    = dv_num_r;

  // divider step
  assign dv_sh = {dv_rem_r, dv_num_r[DIV_NW-1]};
  assign dv_q  = dv_sh >= {1'b0, dv_den_r};

  // square root trial
  assign sq_t = sq_res_r + sq_bit_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_req_type == REQ_LOAD && in_load_last) state_nxt = ST_MEAN_GO;
      end
      ST_MEAN_GO: state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (dv_cnt_r == '0) state_nxt = (axis_r == 2'd2) ? ST_PASS : ST_MEAN_GO;
      end
      ST_PASS: begin
        if (drained) state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_cnt_r == '0) state_nxt = ST_READY;
      end
      ST_READY: begin
        if (accept && in_req_type == REQ_FETCH && rptr_r < count_r) state_nxt = ST_FETCH_RD;
      end
      ST_FETCH_RD: state_nxt = ST_NORM_GO;
      ST_NORM_GO: state_nxt = ST_NORM_WAIT;
      ST_NORM_WAIT: begin
        if (dv_cnt_r == '0) state_nxt = (axis_r == 2'd2) ? ST_EMIT : ST_NORM_GO;
      end
      ST_EMIT: state_nxt = fetch_end ? ST_LOAD : ST_READY;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    busy       = !(state_r == ST_LOAD || state_r == ST_READY);
    ram_we     = 1'b0;
    ram_waddr  = p1_addr_r;
    ram_wdata  = {cc[2], cc[1], cc[0]};
    ram_re     = 1'b0;
    ram_raddr  = pa_r[ADDR_W-1:0];
    div_go     = 1'b0;
    abs_sum    = sum_r[axis_r][SUM_W-1] ? -sum_r[axis_r] : sum_r[axis_r];
    fmag       = mag_of(fc_r[axis_r]);
    div_num_in = DIV_NW'($unsigned(abs_sum)) + DIV_NW'(count_r >> 1);
    div_den_in = DIV_DW'(count_r);
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_req_type == REQ_LOAD && count_r < CNT_W'(MAX_POINTS)) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[ADDR_W-1:0];
          ram_wdata = {sext_coord(in_coord_z), sext_coord(in_coord_y),
                       sext_coord(in_coord_x)};
        end
      end
      ST_MEAN_GO: div_go = 1'b1;
      ST_PASS: begin
        ram_re = issue;
        ram_we = p1_vld_r;
      end
      ST_READY: begin
        ram_re    = accept && in_req_type == REQ_FETCH;
        ram_raddr = rptr_r[ADDR_W-1:0];
      end
      ST_NORM_GO: begin
        div_go     = 1'b1;
        div_num_in = DIV_NW'({fmag, {NORM_FRAC{1'b0}}}) + DIV_NW'(dist_val >> 1);
        div_den_in = DIV_DW'(dist_val);
      end
      ST_MEAN_WAIT, ST_SQRT, ST_FETCH_RD, ST_NORM_WAIT, ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
      count_r   <= '0;
      rptr_r    <= '0;
      axis_r    <= '0;
      pa_r      <= '0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      dv_cnt_r  <= '0;
      sq_cnt_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p1_vld_r  <= issue;
      p2_vld_r  <= p1_vld_r;
      p3_vld_r  <= p2_vld_r;
      if (issue) pa_r <= pa_r + 1'b1;
      if (div_go) begin
        dv_cnt_r <= DIV_CW'(DIV_NW);
      end else if (dv_cnt_r != '0) begin
        dv_cnt_r <= dv_cnt_r - 1'b1;
      end
      if (sq_cnt_r != '0) sq_cnt_r <= sq_cnt_r - 1'b1;
      // result strobe: fetch with nothing pending, or a finished fetch
      out_valid <= (accept && in_req_type == REQ_FETCH &&
                    (state_r == ST_LOAD || rptr_r >= count_r)) || (state_r == ST_EMIT);
      unique case (state_r)
        ST_LOAD: begin
          axis_r <= '0;
          if (accept && in_req_type == REQ_LOAD && count_r < CNT_W'(MAX_POINTS)) begin
            sum_r[0] <= sum_r[0] + SUM_W'(sext_coord(in_coord_x));
            sum_r[1] <= sum_r[1] + SUM_W'(sext_coord(in_coord_y));
            sum_r[2] <= sum_r[2] + SUM_W'(sext_coord(in_coord_z));
            count_r  <= count_r + 1'b1;
          end
        end
        ST_MEAN_WAIT: begin
          if (dv_cnt_r == '0) begin
            axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 1'b1;
            pa_r   <= '0;
          end
        end
        ST_PASS: begin
          if (drained) sq_cnt_r <= SQ_CW'(SQ_STEPS);
        end
        ST_SQRT: rptr_r <= '0;
        ST_FETCH_RD: axis_r <= '0;
        ST_NORM_WAIT: begin
          if (dv_cnt_r == '0) axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 1'b1;
        end
        ST_EMIT: begin
          if (fetch_end) begin
            for (int k = 0; k < 3; k++) sum_r[k] <= '0;
            count_r <= '0;
            rptr_r  <= '0;
          end else begin
            rptr_r <= rptr_r + 1'b1;
          end
        end
        ST_MEAN_GO, ST_READY, ST_NORM_GO: begin
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // pass pipeline: magnitudes, quarter squares, running maximum
    p1_addr_r <= pa_r[ADDR_W-1:0];
    for (int k = 0; k < 3; k++) begin
      m_r[k]  <= mag_of(cc[k]);
      sq_r[k] <= (DSQ_W'(m_r[k]) * DSQ_W'(m_r[k])) >> 2;
    end
    if (state_r == ST_MEAN_WAIT) begin
      maxsq_r <= '0;
    end else if (p3_vld_r && dsq > maxsq_r) begin
      maxsq_r <= dsq;
    end

    // shared restoring divider
    if (div_go) begin
      dv_num_r <= div_num_in;
      dv_den_r <= div_den_in;
      dv_rem_r <= '0;
    end else if (dv_cnt_r != '0) begin
      dv_rem_r <= dv_q ? DIV_DW'(dv_sh - {1'b0, dv_den_r}) : dv_sh[DIV_DW-1:0];
      dv_num_r <= {dv_num_r[DIV_NW-2:0], dv_q};
    end

    // centroid result
    if (state_r == ST_MEAN_WAIT && dv_cnt_r == '0) begin
      if (count_r == '0) begin
        cent_r[axis_r] <= '0;
      end else if (sum_r[axis_r][SUM_W-1]) begin
        cent_r[axis_r] <= -cval_t'(qsel[CW_S-1:0]);
      end else begin
        cent_r[axis_r] <= cval_t'(qsel[CW_S-1:0]);
      end
    end

    // bit-pair square root of the largest quarter squared distance
    if (state_r == ST_PASS) begin
      sq_v_r   <= maxsq_r;
      sq_res_r <= '0;
      sq_bit_r <= DSQ_W'(1) << (DSQ_W - 2);
    end else if (state_r == ST_SQRT && sq_cnt_r != '0) begin
      if (sq_v_r >= sq_t) begin
        sq_v_r   <= sq_v_r - sq_t;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end

    // fetch word and per-axis quotients
    if (state_r == ST_FETCH_RD) begin
      for (int k = 0; k < 3; k++) fc_r[k] <= $signed(ram_rdata[k*CW_S +: CW_S]);
    end
    if (state_r == ST_NORM_WAIT && dv_cnt_r == '0) begin
      nrm_r[axis_r] <= (dist_val == '0) ? '0 : sat_q(qsel, fc_r[axis_r][CW_S-1]);
    end

    // result beat payload
    if (state_r == ST_EMIT) begin
      out_norm_x  <= nrm_r[0];
      out_norm_y  <= nrm_r[1];
      out_norm_z  <= nrm_r[2];
      out_last    <= fetch_end;
      out_no_data <= 1'b0;
    end else begin
      out_norm_x  <= '0;
      out_norm_y  <= '0;
      out_norm_z  <= '0;
      out_last    <= 1'b0;
      out_no_data <= 1'b1;
    end
  end

  // loads never produce a result beat
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_LOAD) |=> !out_valid)
    else $error("result beat after a load");

  // memory is written only while loading or centering
  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_LOAD || state_r == ST_PASS))
    else $error("point memory written outside load or pass");

  // point count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

endmodule
